// File: rtl/core/hpsmc_pkg.sv
// Shared types and constants for the hydrogen pair swap engine.
// No dependencies; used by hydrogen_pair_swap_monte_carlo.
package hpsmc_pkg;

    // Default storage sizes
    localparam int unsigned DEF_MAX_OXYGENS = 1024;
    localparam int unsigned DEF_MAX_PAIRS   = 2048;

    // Field widths
    localparam int unsigned OXY_W   = 10;
    localparam int unsigned PAIR_W  = 11;
    localparam int unsigned WATER_W = 11;
    localparam int unsigned COUNT_W = 3;

    // Count rules
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 3'd7;
    localparam logic [COUNT_W-1:0] RULE_COUNT = 3'd2;

    // water_count after reset
    localparam int unsigned WATER_RESET = 16;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROPOSE = 1'b1
    } op_t;

    // Input item
    typedef struct packed {
        op_t               operation;
        logic [PAIR_W-1:0] pair_index;
        logic [OXY_W-1:0]  first_oxygen;
        logic [OXY_W-1:0]  second_oxygen;
        logic              coin;
    } hpsmc_in_t;

    // Result item
    typedef struct packed {
        logic             accepted;
        logic [OXY_W-1:0] owner_now;
        logic             all_placed;
    } hpsmc_out_t;

    // One pair table entry
    typedef struct packed {
        logic [OXY_W-1:0] first_ox;
        logic [OXY_W-1:0] second_ox;
        logic             first_owns;
    } pair_entry_t;

endpackage

// File: rtl/core/hydrogen_pair_swap_monte_carlo.sv
// Hydrogen pair swap engine: pair table, hydrogen count store and sequencer.
// Depends on hpsmc_pkg (types, widths, count rules).
//
// Every input item gives exactly one result item. A load goes from acceptance
// through ST_LD_WR to its result; a propose goes through ST_PR_RD and ST_PR_DEC,
// and through ST_PR_INC as well when the swap is carried out, since the two count
// updates share the count memory's single write port and each read waits for
// registered data. An item with an out-of-range pair or oxygen index goes
// through ST_SKIP. One item is worked at a time; the next is taken once the
// previous result is registered. After reset a clearing pass writes the count
// memory, during which no item is taken (water_count writes are). A water_count
// write outside that pass recounts the oxygens with two hydrogens over the new
// range (water_count clamped to MAX_OXYGENS), with both ports held off.
module hydrogen_pair_swap_monte_carlo #(
    parameter int unsigned MAX_OXYGENS = hpsmc_pkg::DEF_MAX_OXYGENS,
    parameter int unsigned MAX_PAIRS   = hpsmc_pkg::DEF_MAX_PAIRS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  hpsmc_pkg::hpsmc_in_t            s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output hpsmc_pkg::hpsmc_out_t           m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpsmc_pkg::WATER_W-1:0]   cfg_data
);

    localparam int unsigned OX_AW = $clog2(MAX_OXYGENS);
    localparam int unsigned PR_AW = $clog2(MAX_PAIRS);
    localparam int unsigned OX_CW = $clog2(MAX_OXYGENS + 1);
    localparam int unsigned IN_USE_RST = (hpsmc_pkg::WATER_RESET >= MAX_OXYGENS) ?
                                         MAX_OXYGENS : hpsmc_pkg::WATER_RESET;

    localparam int unsigned OXY_W   = hpsmc_pkg::OXY_W;
    localparam int unsigned COUNT_W = hpsmc_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECOUNT,
        ST_SKIP,
        ST_LD_WR,
        ST_PR_RD,
        ST_PR_DEC,
        ST_PR_INC
    } state_t;

    // Memories
    hpsmc_pkg::pair_entry_t pair_mem [0:MAX_PAIRS-1];
    logic [COUNT_W-1:0]     count_mem [0:MAX_OXYGENS-1];

    // Memory ports
    logic                   pair_we;
    logic [PR_AW-1:0]       pair_wa;
    hpsmc_pkg::pair_entry_t pair_wd;
    logic [PR_AW-1:0]       pair_ra;
    hpsmc_pkg::pair_entry_t pair_rdata_reg;

    logic                   cnt_we;
    logic [OX_AW-1:0]       cnt_wa;
    logic [COUNT_W-1:0]     cnt_wd;
    logic [OX_AW-1:0]       cnt_ra0;
    logic [OX_AW-1:0]       cnt_ra1;
    logic [COUNT_W-1:0]     cnt_rdata0_reg;
    logic [COUNT_W-1:0]     cnt_rdata1_reg;

    // Control state
    state_t                 state_reg, state_next;
    logic [OX_CW-1:0]       sweep_reg, sweep_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [OX_CW-1:0]       in_use_reg, in_use_next;
    logic [OX_CW-1:0]       owt_reg, owt_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload state
    hpsmc_pkg::hpsmc_in_t   item_reg, item_next;
    hpsmc_pkg::pair_entry_t entry_reg, entry_next;
    logic [OXY_W-1:0]       owner_reg, owner_next;
    logic [OXY_W-1:0]       partner_reg, partner_next;
    logic [COUNT_W-1:0]     part_cnt_reg, part_cnt_next;
    hpsmc_pkg::hpsmc_out_t  m_data_reg, m_data_next;

    // Decision terms
    logic                   out_free;
    logic                   pair_ok;
    logic                   load_ox_ok;
    logic [COUNT_W:0]       co_w;
    logic [COUNT_W:0]       cp_w;
    logic                   swap_ok;
    logic [COUNT_W-1:0]     new_cnt;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == hpsmc_pkg::COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_dec(input logic [COUNT_W-1:0] c);
        return (c == '0) ? c : c - COUNT_W'(1);
    endfunction

    // Track oxygens in use with exactly two hydrogens across one count write
    function automatic logic [OX_CW-1:0] owt_adjust(
        input logic [OX_CW-1:0]   owt,
        input logic [OXY_W-1:0]   ox,
        input logic [COUNT_W-1:0] old_c,
        input logic [COUNT_W-1:0] new_c,
        input logic [OX_CW-1:0]   n_use
    );
        logic [OX_CW-1:0] res;
        res = owt;
        if (32'(ox) < 32'(n_use)) begin
            if (old_c == hpsmc_pkg::RULE_COUNT && new_c != hpsmc_pkg::RULE_COUNT) begin
                res = owt - OX_CW'(1);
            end else if (old_c != hpsmc_pkg::RULE_COUNT &&
                         new_c == hpsmc_pkg::RULE_COUNT) begin
                res = owt + OX_CW'(1);
            end
        end
        return res;
    endfunction

    // Pair table: one write, one registered read
    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pair_mem[pair_wa] <= pair_wd;
        end
        pair_rdata_reg <= pair_mem[pair_ra];
    end

    // Count store: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rdata0_reg <= count_mem[cnt_ra0];
        cnt_rdata1_reg <= count_mem[cnt_ra1];
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign pair_ok    = 32'(s_data.pair_index) < MAX_PAIRS;
    assign load_ox_ok = (32'(s_data.first_oxygen) < MAX_OXYGENS) &&
                        (32'(s_data.second_oxygen) < MAX_OXYGENS);

    // Swap rule: difference co - cp of two or more lowers imbalance, one is a tie
    assign co_w    = {1'b0, cnt_rdata0_reg};
    assign cp_w    = {1'b0, cnt_rdata1_reg};
    assign swap_ok = (co_w > cp_w + (COUNT_W + 1)'(1)) ||
                     ((co_w == cp_w + (COUNT_W + 1)'(1)) && item_reg.coin);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        rd_vld_next   = rd_vld_reg;
        in_use_next   = in_use_reg;
        owt_next      = owt_reg;
        m_valid_next  = m_valid_reg;
        item_next     = item_reg;
        entry_next    = entry_reg;
        owner_next    = owner_reg;
        partner_next  = partner_reg;
        part_cnt_next = part_cnt_reg;
        m_data_next   = m_data_reg;

        pair_we = 1'b0;
        pair_wa = PR_AW'(item_reg.pair_index);
        pair_wd = entry_reg;
        pair_ra = PR_AW'(s_data.pair_index);
        cnt_we  = 1'b0;
        cnt_wa  = OX_AW'(owner_reg);
        cnt_wd  = '0;
        cnt_ra0 = OX_AW'(owner_reg);
        cnt_ra1 = OX_AW'(partner_reg);
        new_cnt = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // water_count write, clamped to the store size
        if (cfg_valid && cfg_ready) begin
            in_use_next = (32'(cfg_data) >= MAX_OXYGENS) ? OX_CW'(MAX_OXYGENS)
                                                         : OX_CW'(cfg_data);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we     = 1'b1;
                cnt_wa     = sweep_reg[OX_AW-1:0];
                cnt_wd     = '0;
                sweep_next = sweep_reg + OX_CW'(1);
                if (sweep_reg == OX_CW'(MAX_OXYGENS - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                cnt_ra0 = OX_AW'(s_data.coin ? s_data.second_oxygen : s_data.first_oxygen);
                if (cfg_valid) begin
                    state_next  = ST_RECOUNT;
                    sweep_next  = '0;
                    rd_vld_next = 1'b0;
                    owt_next    = '0;
                end else if (s_valid) begin
                    item_next = s_data;
                    if (!pair_ok) begin
                        state_next = ST_SKIP;
                    end else if (s_data.operation == hpsmc_pkg::OP_LOAD) begin
                        if (!load_ox_ok) begin
                            state_next = ST_SKIP;
                        end else begin
                            pair_we            = 1'b1;
                            pair_wa            = PR_AW'(s_data.pair_index);
                            pair_wd.first_ox   = s_data.first_oxygen;
                            pair_wd.second_ox  = s_data.second_oxygen;
                            pair_wd.first_owns = !s_data.coin;
                            owner_next = s_data.coin ? s_data.second_oxygen
                                                     : s_data.first_oxygen;
                            state_next = ST_LD_WR;
                        end
                    end else begin
                        state_next = ST_PR_RD;
                    end
                end
            end

            ST_RECOUNT: begin
                cnt_ra0 = sweep_reg[OX_AW-1:0];
                if (rd_vld_reg && cnt_rdata0_reg == hpsmc_pkg::RULE_COUNT) begin
                    owt_next = owt_reg + OX_CW'(1);
                end
                if (sweep_reg < in_use_reg) begin
                    sweep_next  = sweep_reg + OX_CW'(1);
                    rd_vld_next = 1'b1;
                end else begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SKIP: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.accepted   = 1'b0;
                    m_data_next.owner_now  = '0;
                    m_data_next.all_placed = (owt_reg == in_use_reg);
                    state_next             = ST_IDLE;
                end
            end

            // Load: raise the new owner's count
            ST_LD_WR: begin
                if (out_free) begin
                    new_cnt  = sat_inc(cnt_rdata0_reg);
                    cnt_we   = 1'b1;
                    cnt_wa   = OX_AW'(owner_reg);
                    cnt_wd   = new_cnt;
                    owt_next = owt_adjust(owt_reg, owner_reg, cnt_rdata0_reg,
                                          new_cnt, in_use_reg);
                    m_valid_next           = 1'b1;
                    m_data_next.accepted   = 1'b0;
                    m_data_next.owner_now  = owner_reg;
                    m_data_next.all_placed = (owt_next == in_use_reg);
                    state_next             = ST_IDLE;
                end
            end

            // Propose: pair entry is in, fetch both counts
            ST_PR_RD: begin
                entry_next = pair_rdata_reg;
                if (pair_rdata_reg.first_owns) begin
                    owner_next   = pair_rdata_reg.first_ox;
                    partner_next = pair_rdata_reg.second_ox;
                end else begin
                    owner_next   = pair_rdata_reg.second_ox;
                    partner_next = pair_rdata_reg.first_ox;
                end
                cnt_ra0    = OX_AW'(owner_next);
                cnt_ra1    = OX_AW'(partner_next);
                state_next = ST_PR_DEC;
            end

            // Decide; on a swap lower the owner and flip the pair's flag
            ST_PR_DEC: begin
                if (swap_ok) begin
                    new_cnt            = sat_dec(cnt_rdata0_reg);
                    cnt_we             = 1'b1;
                    cnt_wa             = OX_AW'(owner_reg);
                    cnt_wd             = new_cnt;
                    owt_next           = owt_adjust(owt_reg, owner_reg, cnt_rdata0_reg,
                                                    new_cnt, in_use_reg);
                    part_cnt_next      = cnt_rdata1_reg;
                    pair_we            = 1'b1;
                    pair_wd            = entry_reg;
                    pair_wd.first_owns = !entry_reg.first_owns;
                    state_next         = ST_PR_INC;
                end else if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.accepted   = 1'b0;
                    m_data_next.owner_now  = owner_reg;
                    m_data_next.all_placed = (owt_reg == in_use_reg);
                    state_next             = ST_IDLE;
                end
            end

            // Raise the partner's count and report the swap
            ST_PR_INC: begin
                if (out_free) begin
                    new_cnt  = sat_inc(part_cnt_reg);
                    cnt_we   = 1'b1;
                    cnt_wa   = OX_AW'(partner_reg);
                    cnt_wd   = new_cnt;
                    owt_next = owt_adjust(owt_reg, partner_reg, part_cnt_reg,
                                          new_cnt, in_use_reg);
                    m_valid_next           = 1'b1;
                    m_data_next.accepted   = 1'b1;
                    m_data_next.owner_now  = partner_reg;
                    m_data_next.all_placed = (owt_next == in_use_reg);
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            in_use_reg  <= OX_CW'(IN_USE_RST);
            owt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            rd_vld_reg  <= rd_vld_next;
            in_use_reg  <= in_use_next;
            owt_reg     <= owt_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg     <= item_next;
        entry_reg    <= entry_next;
        owner_reg    <= owner_next;
        partner_reg  <= partner_next;
        part_cnt_reg <= part_cnt_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// File: bench/tb_hydrogen_pair_swap_monte_carlo.sv
// Self-checking bench for hydrogen_pair_swap_monte_carlo: scripted and random items,
// each result compared with a built-in lattice predictor.
// Depends on hpsmc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_hydrogen_pair_swap_monte_carlo;

    localparam int OXY_W   = hpsmc_pkg::OXY_W;
    localparam int PAIR_W  = hpsmc_pkg::PAIR_W;
    localparam int WATER_W = hpsmc_pkg::WATER_W;
    localparam int COUNT_W = hpsmc_pkg::COUNT_W;
    localparam int N_PAIRS = hpsmc_pkg::DEF_MAX_PAIRS;
    localparam int N_OXY   = hpsmc_pkg::DEF_MAX_OXYGENS;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RING_ITEMS  = 1400;
    localparam int STRAY_PAIR  = 1536;   // pairs from here up hold noise on high oxygens
    localparam int STRAY_OXY   = 900;
    localparam int SCRIPT_LEN  = 16;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    hpsmc_pkg::hpsmc_in_t  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    hpsmc_pkg::hpsmc_out_t m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [WATER_W-1:0]    cfg_data  = '0;

    hydrogen_pair_swap_monte_carlo dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predictor state: pair table, hydrogen counts, oxygens in use
    logic [OXY_W-1:0]   pair_a      [N_PAIRS] = '{default: '0};
    logic [OXY_W-1:0]   pair_b      [N_PAIRS] = '{default: '0};
    logic               a_owns      [N_PAIRS] = '{default: 1'b0};
    logic               pair_loaded [N_PAIRS] = '{default: 1'b0};
    logic [COUNT_W-1:0] h_count     [N_OXY]   = '{default: '0};
    logic [WATER_W-1:0] water_n = WATER_W'(hpsmc_pkg::WATER_RESET);

    hpsmc_pkg::hpsmc_out_t pending [$];      // results still owed by the block, oldest first
    int                    loaded_list [$];  // every pair index loaded so far
    int                    stray_pairs [$];  // loaded pairs living on high oxygens
    int                    fail_cnt   = 0;
    int                    items_done = 0;
    int                    cycle_cnt  = 0;
    int                    ring_base  = 0;   // first oxygen of the next ring window
    int                    ring_pair  = 0;   // next pair index for ring loads
    bit                    quiet_send = 1'b0;
    bit                    sink_calm  = 1'b0;
    int                    sink_hold  = 0;
    hpsmc_pkg::hpsmc_out_t want_res;

    // Scripted items; typed results only where they follow directly
    typedef struct packed {
        logic                  typed;
        hpsmc_pkg::hpsmc_in_t  item;
        hpsmc_pkg::hpsmc_out_t res;
    } script_row_t;

    script_row_t script [SCRIPT_LEN] = '{
        // load pair 0 to second oxygen, zero first oxygen field
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd0,    10'd0,    10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        // top pair, both oxygens the same
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd2047, 10'd1023, 10'd1023, 1'b0},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_PROPOSE, 11'd2047, 10'd0,    10'd0,    1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        // tie: coin 0 rejects, coin 1 accepts
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1536, 10'd1022, 10'd1000, 1'b0},
          '{1'b0, 10'd1022, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_PROPOSE, 11'd1536, 10'd0,    10'd0,    1'b0},
          '{1'b0, 10'd1022, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_PROPOSE, 11'd1536, 10'd0,    10'd0,    1'b1},
          '{1'b1, 10'd1000, 1'b0}},
        // drive oxygen 1023 into count saturation
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1537, 10'd1001, 10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1538, 10'd1001, 10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1539, 10'd1001, 10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1540, 10'd1001, 10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1541, 10'd1001, 10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1542, 10'd1001, 10'd1023, 1'b1},
          '{1'b0, 10'd1023, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_LOAD,    11'd1543, 10'd1001, 10'd1023, 1'b0},
          '{1'b0, 10'd1001, 1'b0}},
        // strict improvement accepted, then the reverse move rejected
        '{1'b1, '{hpsmc_pkg::OP_PROPOSE, 11'd1537, 10'd0,    10'd0,    1'b0},
          '{1'b1, 10'd1001, 1'b0}},
        '{1'b1, '{hpsmc_pkg::OP_PROPOSE, 11'd1537, 10'd0,    10'd0,    1'b0},
          '{1'b0, 10'd1001, 1'b0}},
        '{1'b0, '{hpsmc_pkg::OP_PROPOSE, 11'd1538, 10'd1023, 10'd1023, 1'b1},
          '{1'b0, 10'd0,    1'b0}}
    };

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Random gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (quiet_send || $urandom_range(0, 1) == 0)
            return 0;
        return pick_gap();
    endfunction

    // Ice rule: every oxygen in use holds exactly two hydrogens
    function automatic bit ice_rule_met();
        int n;
        int hits;
        n = (int'(water_n) > N_OXY) ? N_OXY : int'(water_n);
        hits = 0;
        for (int i = 0; i < n; i++)
            if (h_count[i] == hpsmc_pkg::RULE_COUNT)
                hits++;
        return hits == n;
    endfunction

    // Apply one item to the predicted lattice and return its result
    function automatic hpsmc_pkg::hpsmc_out_t advance_lattice(input hpsmc_pkg::hpsmc_in_t item);
        hpsmc_pkg::hpsmc_out_t res;
        int p;
        int own;
        int mate;
        int co;
        int cp;
        int gap_now;
        int gap_try;
        bit take;
        res = '0;
        p = int'(item.pair_index);
        if (item.operation == hpsmc_pkg::OP_LOAD) begin
            pair_a[p] = item.first_oxygen;
            pair_b[p] = item.second_oxygen;
            a_owns[p] = !item.coin;
            if (!pair_loaded[p])
                loaded_list = {loaded_list, p};
            pair_loaded[p] = 1'b1;
            own = int'(item.coin ? item.second_oxygen : item.first_oxygen);
            if (h_count[own] != hpsmc_pkg::COUNT_MAX)
                h_count[own] = h_count[own] + COUNT_W'(1);
            res.owner_now = OXY_W'(own);
        end else begin
            own  = int'(a_owns[p] ? pair_a[p] : pair_b[p]);
            mate = int'(a_owns[p] ? pair_b[p] : pair_a[p]);
            co = int'(h_count[own]);
            cp = int'(h_count[mate]);
            gap_now = (co - cp < 0) ? cp - co : co - cp;
            gap_try = (co - cp - 2 < 0) ? cp + 2 - co : co - cp - 2;
            take = (gap_try < gap_now) || (gap_try == gap_now && item.coin);
            if (take) begin
                if (h_count[own] != '0)
                    h_count[own] = h_count[own] - COUNT_W'(1);
                if (h_count[mate] != hpsmc_pkg::COUNT_MAX)
                    h_count[mate] = h_count[mate] + COUNT_W'(1);
                a_owns[p] = !a_owns[p];
            end
            res.accepted  = take;
            res.owner_now = OXY_W'(take ? mate : own);
        end
        res.all_placed = ice_rule_met();
        return res;
    endfunction

    // Result checker
    task automatic note_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_val, act_val);
        fail_cnt++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                $display("%0t ns: result item with none expected, got %h",
                         $time, m_data);
                fail_cnt++;
            end else begin
                want_res = pending.pop_front();
                if (m_data.accepted != want_res.accepted)
                    note_mismatch("accepted", int'(want_res.accepted),
                                  int'(m_data.accepted));
                if (m_data.owner_now != want_res.owner_now)
                    note_mismatch("owner_now", int'(want_res.owner_now),
                                  int'(m_data.owner_now));
                if (m_data.all_placed != want_res.all_placed)
                    note_mismatch("all_placed", int'(want_res.all_placed),
                                  int'(m_data.all_placed));
            end
        end
    end

    // Result side backpressure, with calm stretches of no stall
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0)
            sink_calm = !sink_calm;
        if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else if (sink_calm || $urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            sink_hold = pick_gap() - 1;
            m_ready <= 1'b0;
        end
    end

    // Offer one item, wait for acceptance, queue its expected result
    task automatic offer_item(input hpsmc_pkg::hpsmc_in_t item, input bit typed,
                              input hpsmc_pkg::hpsmc_out_t typed_res);
        int gap;
        hpsmc_pkg::hpsmc_out_t res;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        res = advance_lattice(item);
        if (typed)
            res = typed_res;
        pending = {pending, res};
        items_done++;
    endtask

    // Hold the sender until every owed result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_water(input int value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= WATER_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        water_n = WATER_W'(value);
    endtask

    // Occasional item on the high oxygens, away from the ring window
    task automatic maybe_stray();
        hpsmc_pkg::hpsmc_in_t item;
        if ($urandom_range(0, 9) != 0)
            return;
        item = '0;
        if (stray_pairs.size() == 0 || $urandom_range(0, 1) == 0) begin
            item.operation     = hpsmc_pkg::OP_LOAD;
            item.pair_index    = PAIR_W'($urandom_range(STRAY_PAIR, N_PAIRS - 1));
            item.first_oxygen  = OXY_W'($urandom_range(STRAY_OXY, N_OXY - 1));
            item.second_oxygen = OXY_W'($urandom_range(STRAY_OXY, N_OXY - 1));
            stray_pairs = {stray_pairs, int'(item.pair_index)};
        end else begin
            item.operation     = hpsmc_pkg::OP_PROPOSE;
            item.pair_index    =
                PAIR_W'(stray_pairs[$urandom_range(0, stray_pairs.size() - 1)]);
            item.first_oxygen  = OXY_W'($urandom);
            item.second_oxygen = OXY_W'($urandom);
        end
        item.coin = 1'($urandom_range(0, 1));
        offer_item(item, 1'b0, '0);
    endtask

    // Double ring on a new oxygen window, then swaps till the ice rule holds or budget ends
    task automatic ring_phase();
        int k_size;
        int budget;
        int extra;
        int pick;
        int own;
        int phase_pairs [$];
        int hot [$];
        hpsmc_pkg::hpsmc_in_t item;
        k_size = $urandom_range(3, 12);
        write_water(ring_base + k_size);
        quiet_send = ($urandom_range(0, 3) == 0);
        item = '0;
        for (int k = 0; k < k_size; k++) begin
            for (int j = 1; j <= 2; j++) begin
                maybe_stray();
                item.operation     = hpsmc_pkg::OP_LOAD;
                item.pair_index    = PAIR_W'(ring_pair);
                item.first_oxygen  = OXY_W'(ring_base + k);
                item.second_oxygen = OXY_W'(ring_base + (k + j) % k_size);
                item.coin          = 1'($urandom_range(0, 1));
                offer_item(item, 1'b0, '0);
                phase_pairs = {phase_pairs, ring_pair};
                ring_pair++;
            end
        end
        settle();
        budget = 12 * k_size;
        extra  = k_size;
        while (budget > 0 && extra > 0) begin
            maybe_stray();
            hot.delete();
            foreach (phase_pairs[i]) begin
                own = int'(a_owns[phase_pairs[i]] ? pair_a[phase_pairs[i]]
                                                  : pair_b[phase_pairs[i]]);
                if (h_count[own] > hpsmc_pkg::RULE_COUNT)
                    hot = {hot, phase_pairs[i]};
            end
            if (hot.size() != 0 && $urandom_range(0, 3) != 0)
                pick = hot[$urandom_range(0, hot.size() - 1)];
            else
                pick = phase_pairs[$urandom_range(0, phase_pairs.size() - 1)];
            item.operation     = hpsmc_pkg::OP_PROPOSE;
            item.pair_index    = PAIR_W'(pick);
            item.first_oxygen  = OXY_W'($urandom);
            item.second_oxygen = OXY_W'($urandom);
            item.coin          = 1'($urandom_range(0, 1));
            offer_item(item, 1'b0, '0);
            budget--;
            if (ice_rule_met())
                extra--;
        end
        ring_base += k_size;
    endtask

    // Unstructured traffic over the whole index range at a given oxygen count
    task automatic noise_phase(input int which);
        hpsmc_pkg::hpsmc_in_t item;
        int value;
        case (which)
            0: value = 0;
            1: value = (1 << WATER_W) - 1;
            2: value = 1;
            3: value = N_OXY;
            default: value = $urandom_range(0, (1 << WATER_W) - 1);
        endcase
        write_water(value);
        quiet_send = ($urandom_range(0, 3) == 0);
        repeat (110) begin
            item = '0;
            item.first_oxygen  = OXY_W'($urandom);
            item.second_oxygen = OXY_W'($urandom);
            item.coin          = 1'($urandom_range(0, 1));
            if (loaded_list.size() == 0 || $urandom_range(0, 99) < 40) begin
                item.operation  = hpsmc_pkg::OP_LOAD;
                item.pair_index = PAIR_W'($urandom_range(0, N_PAIRS - 1));
            end else begin
                item.operation  = hpsmc_pkg::OP_PROPOSE;
                item.pair_index =
                    PAIR_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
            end
            offer_item(item, 1'b0, '0);
        end
    endtask

    // Main sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
            offer_item(script[i].item, script[i].typed, script[i].res);
        for (int p = STRAY_PAIR; p <= STRAY_PAIR + 7; p++)
            stray_pairs = {stray_pairs, p};
        stray_pairs = {stray_pairs, N_PAIRS - 1};

        while (items_done < RING_ITEMS && ring_base + 12 < STRAY_OXY
               && ring_pair + 24 < STRAY_PAIR)
            ring_phase();
        for (int k = 0; k < 5; k++)
            noise_phase(k);

        settle();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/core/hpsmc_pkg.sv
rtl/core/hydrogen_pair_swap_monte_carlo.sv
bench/tb_hydrogen_pair_swap_monte_carlo.sv
